// File: rtl/cat_pkg.sv
// shared widths, command codes and control types for the scroll tween
package cat_pkg;

    // field and state widths
    localparam int PIX_W     = 16;
    localparam int FRM_W     = 12;
    localparam int POS_W     = 21;
    localparam int ACC_W     = 32;
    localparam int FRAC_BITS = 4;
    localparam int DIFF_W    = PIX_W + 1;
    localparam int DEN_W     = 2 * FRM_W;

    // numerator is (target - pixel) scaled by 16 and doubled by the gain of two
    localparam int NUM_SHIFT = FRAC_BITS + 1;
    localparam int NUM_W     = PIX_W + NUM_SHIFT;

    // serial step counts
    localparam int MUL_STEPS = FRM_W;
    localparam int DIV_STEPS = NUM_W;
    localparam int ADD_STEPS = ACC_W;
    localparam int CNT_W     = $clog2(ADD_STEPS);

    // command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // control from the sequencer to each axis
    typedef struct packed {
        logic start;
        logic acc_load;
        logic clr_carry;
        logic step;
        logic pos_en;
        logic finish;
        logic snap;
    } t_axis_ctl;

endpackage

// File: rtl/cat_if.sv
// valid/ready channels for the command words and the scroll result words
interface cat_in_if import cat_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    cmd;
    logic signed [PIX_W-1:0] dest_x;
    logic signed [PIX_W-1:0] dest_y;
    logic        [FRM_W-1:0] frames;

    modport source (output valid, cmd, dest_x, dest_y, frames, input ready);
    modport sink   (input valid, cmd, dest_x, dest_y, frames, output ready);
endinterface

interface cat_out_if import cat_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [PIX_W-1:0] scroll_x;
    logic signed [PIX_W-1:0] scroll_y;
    logic                    moving;
    logic                    ended;

    modport source (output valid, scroll_x, scroll_y, moving, ended, input ready);
    modport sink   (input valid, scroll_x, scroll_y, moving, ended, output ready);
endinterface

// File: rtl/cat_div.sv
// bit-serial restoring divider giving the signed acceleration of one axis
module cat_div import cat_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_load,
    input  logic                     i_step,
    input  logic signed [DIFF_W-1:0] i_diff,
    input  logic        [DEN_W-1:0]  i_den,
    output logic signed [ACC_W-1:0]  o_quot
);

    logic [DEN_W-1:0] r_rem;
    logic [NUM_W-1:0] r_quo;
    logic             r_neg;

    logic [DIFF_W-1:0] mag;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    sub;
    logic              ge;
    logic [ACC_W-1:0]  quo_ext;

    // magnitude of the difference and one trial subtract per step
    always_comb begin
        mag     = i_diff[DIFF_W-1] ? DIFF_W'(-i_diff) : DIFF_W'(i_diff);
        trial   = {r_rem, r_quo[NUM_W-1]};
        ge      = (trial >= {1'b0, i_den});
        sub     = trial - {1'b0, i_den};
        quo_ext = {{(ACC_W-NUM_W){1'b0}}, r_quo};
        o_quot  = r_neg ? -quo_ext : quo_ext;
    end

    // dividend shifts out of the quotient register while quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_neg <= i_diff[DIFF_W-1];
            r_rem <= '0;
            r_quo <= {mag[PIX_W-1:0], {NUM_SHIFT{1'b0}}};
        end else if (i_step) begin
            r_rem <= ge ? sub[DEN_W-1:0] : trial[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], ge};
        end
    end

endmodule

// File: rtl/cat_axis.sv
// one axis: position, velocity and acceleration with a bit-serial integrator
module cat_axis import cat_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_axis_ctl                i_ctl,
    input  logic signed [PIX_W-1:0]  i_target,
    input  logic signed [ACC_W-1:0]  i_acc,
    output logic signed [DIFF_W-1:0] o_diff,
    output logic signed [PIX_W-1:0]  o_pix
);

    logic signed [PIX_W-1:0] r_pix;
    logic        [POS_W-1:0] r_pos;
    logic        [POS_W-1:0] r_goal;
    logic        [ACC_W-1:0] r_vel;
    logic        [ACC_W-1:0] r_acc;
    logic                    r_cv;
    logic                    r_cp;

    logic              sum_v;
    logic              n_cv;
    logic              sum_p;
    logic              n_cp;
    logic [POS_W-1:0]  pos_src;
    logic [POS_W-1:0]  pos_adj;
    logic [DIFF_W-1:0] q_pix;
    logic [PIX_W-1:0]  pix_sat;

    // serial adders: velocity plus acceleration, then position plus new velocity bit
    always_comb begin
        sum_v = r_vel[0] ^ r_acc[0] ^ r_cv;
        n_cv  = (r_vel[0] & r_acc[0]) | (r_vel[0] & r_cv) | (r_acc[0] & r_cv);
        sum_p = r_pos[0] ^ sum_v ^ r_cp;
        n_cp  = (r_pos[0] & sum_v) | (r_pos[0] & r_cp) | (sum_v & r_cp);
    end

    // pixel from position: divide by 16 toward zero, then saturate
    always_comb begin
        pos_src = i_ctl.snap ? r_goal : r_pos;
        pos_adj = pos_src + (pos_src[POS_W-1] ? POS_W'((1 << FRAC_BITS) - 1) : '0);
        q_pix   = pos_adj[POS_W-1:FRAC_BITS];
        if (q_pix[DIFF_W-1] != q_pix[DIFF_W-2]) begin
            pix_sat = q_pix[DIFF_W-1] ? {1'b1, {(PIX_W-1){1'b0}}} : {1'b0, {(PIX_W-1){1'b1}}};
        end else begin
            pix_sat = q_pix[PIX_W-1:0];
        end
    end

    // goal minus position in whole pixels, valid right after a start
    assign o_diff = DIFF_W'(r_goal[POS_W-1:FRAC_BITS]) - DIFF_W'(r_pos[POS_W-1:FRAC_BITS]);
    assign o_pix  = r_pix;

    // axis state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix  <= '0;
            r_pos  <= '0;
            r_goal <= '0;
            r_vel  <= '0;
            r_acc  <= '0;
            r_cv   <= 1'b0;
            r_cp   <= 1'b0;
        end else begin
            if (i_ctl.start) begin
                r_pos  <= {r_pix[PIX_W-1], r_pix, {FRAC_BITS{1'b0}}};
                r_goal <= {i_target[PIX_W-1], i_target, {FRAC_BITS{1'b0}}};
                r_vel  <= '0;
                r_acc  <= '0;
            end else if (i_ctl.acc_load) begin
                r_acc <= i_acc;
            end else if (i_ctl.clr_carry) begin
                r_cv <= 1'b0;
                r_cp <= 1'b0;
            end else if (i_ctl.step) begin
                r_vel <= {sum_v, r_vel[ACC_W-1:1]};
                r_acc <= {r_acc[0], r_acc[ACC_W-1:1]};
                r_cv  <= n_cv;
                if (i_ctl.pos_en) begin
                    r_pos <= {sum_p, r_pos[POS_W-1:1]};
                    r_cp  <= n_cp;
                end
            end else if (i_ctl.finish) begin
                r_pos <= pos_src;
                r_pix <= pix_sat;
            end
        end
    end

endmodule

// File: rtl/constant_accel_scroll_tween.sv
// top level: command sequencer, serial multiplier, two dividers, two axes and result register
// Two-axis scroll tween with four fractional bits of position. Each command word
// gives exactly one result word. A start word runs a shift-add multiply for
// the squared duration and then a restoring divide on both axes at once, so
// it is busy until both are done before the next word is taken (a zero duration
// skips them). A tick that moves the tween pushes velocity and position through
// bit-serial adders. A tick that retires the tween or finds it idle goes straight
// to the result. The result sits in an output register, so a new word is taken
// while the previous result still waits to be read.
module constant_accel_scroll_tween import cat_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cat_in_if.sink     i_in,
    cat_out_if.source  o_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DLOAD,
        S_DIV,
        S_ACC,
        S_TICK,
        S_FIN,
        S_EMIT
    } t_state;

    t_state                  r_state;
    logic [CNT_W-1:0]        r_cnt;
    logic [FRM_W-1:0]        r_frame_count;
    logic [FRM_W-1:0]        r_frame_total;
    logic                    r_active;
    logic                    r_ended;
    logic                    r_out_valid;
    logic signed [PIX_W-1:0] r_out_x;
    logic signed [PIX_W-1:0] r_out_y;
    logic                    r_out_moving;
    logic                    r_out_ended;

    logic [DEN_W-1:0] r_mcand;
    logic [FRM_W-1:0] r_mplier;
    logic [DEN_W-1:0] r_prod;

    logic                     accept;
    logic                     is_start;
    logic                     is_run;
    t_axis_ctl                axis_ctl;
    logic signed [DIFF_W-1:0] diff_x;
    logic signed [DIFF_W-1:0] diff_y;
    logic signed [ACC_W-1:0]  quot_x;
    logic signed [ACC_W-1:0]  quot_y;
    logic signed [PIX_W-1:0]  pix_x;
    logic signed [PIX_W-1:0]  pix_y;

    // handshake decode
    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign is_start   = accept && (i_in.cmd == CMD_START);
    assign is_run     = accept && (i_in.cmd == CMD_TICK) && r_active
                        && (r_frame_count < r_frame_total);

    // axis control
    always_comb begin
        axis_ctl.start     = is_start;
        axis_ctl.clr_carry = is_run;
        axis_ctl.acc_load  = (r_state == S_ACC);
        axis_ctl.step      = (r_state == S_TICK);
        axis_ctl.pos_en    = (r_cnt < CNT_W'(POS_W));
        axis_ctl.finish    = (r_state == S_FIN);
        axis_ctl.snap      = (r_frame_count >= r_frame_total);
    end

    // shift-add multiply for the squared duration
    always_ff @(posedge i_clk) begin
        if (is_start) begin
            r_mcand  <= DEN_W'(i_in.frames);
            r_mplier <= i_in.frames;
            r_prod   <= '0;
        end else if (r_state == S_MUL) begin
            if (r_mplier[0]) begin
                r_prod <= r_prod + r_mcand;
            end
            r_mcand  <= {r_mcand[DEN_W-2:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[FRM_W-1:1]};
        end
    end

    cat_div u_div_x (
        .i_clk  (i_clk),
        .i_load (r_state == S_DLOAD),
        .i_step (r_state == S_DIV),
        .i_diff (diff_x),
        .i_den  (r_prod),
        .o_quot (quot_x)
    );

    cat_div u_div_y (
        .i_clk  (i_clk),
        .i_load (r_state == S_DLOAD),
        .i_step (r_state == S_DIV),
        .i_diff (diff_y),
        .i_den  (r_prod),
        .o_quot (quot_y)
    );

    cat_axis u_axis_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (axis_ctl),
        .i_target (i_in.dest_x),
        .i_acc    (quot_x),
        .o_diff   (diff_x),
        .o_pix    (pix_x)
    );

    cat_axis u_axis_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (axis_ctl),
        .i_target (i_in.dest_y),
        .i_acc    (quot_y),
        .o_diff   (diff_y),
        .o_pix    (pix_y)
    );

    // sequencer, tween status and result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cnt         <= '0;
            r_frame_count <= '0;
            r_frame_total <= '0;
            r_active      <= 1'b0;
            r_ended       <= 1'b0;
            r_out_valid   <= 1'b0;
            r_out_x       <= '0;
            r_out_y       <= '0;
            r_out_moving  <= 1'b0;
            r_out_ended   <= 1'b0;
        end else begin
            // result word taken, unless the emit state loads a new one this cycle
            if (o_out.valid && o_out.ready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_ended <= 1'b0;
                        r_cnt   <= '0;
                        if (is_start) begin
                            r_frame_total <= i_in.frames;
                            r_frame_count <= '0;
                            r_active      <= 1'b1;
                            r_state       <= (i_in.frames == '0) ? S_EMIT : S_MUL;
                        end else if (is_run) begin
                            r_state <= S_TICK;
                        end else if (r_active) begin
                            r_active <= 1'b0;
                            r_ended  <= 1'b1;
                            r_state  <= S_EMIT;
                        end else begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_MUL: begin
                    if (r_cnt == CNT_W'(MUL_STEPS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_DLOAD;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DLOAD: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_ACC;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_ACC: begin
                    r_state <= S_EMIT;
                end
                S_TICK: begin
                    if (r_cnt == CNT_W'(ADD_STEPS - 1)) begin
                        r_cnt         <= '0;
                        r_frame_count <= r_frame_count + 1'b1;
                        r_state       <= S_FIN;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_FIN: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_x      <= pix_x;
                        r_out_y      <= pix_y;
                        r_out_moving <= r_active;
                        r_out_ended  <= r_ended;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result channel
    assign o_out.valid    = r_out_valid;
    assign o_out.scroll_x = r_out_x;
    assign o_out.scroll_y = r_out_y;
    assign o_out.moving   = r_out_moving;
    assign o_out.ended    = r_out_ended;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state != S_IDLE))
        else $error("sequencer did not leave idle after taking a word");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_frame_count <= r_frame_total))
        else $error("frame count ran past the tween duration");

    a_ended_not_moving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_ended) |-> !r_out_moving)
        else $error("result word reports a retired tween as still moving");

    a_div_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt < CNT_W'(DIV_STEPS)))
        else $error("divider step count out of range");
`endif

endmodule

// File: verif/tb_constant_accel_scroll_tween.sv
`timescale 1ns / 1ps
// self-checking testbench for the two-axis constant-acceleration scroll tween
module tb_constant_accel_scroll_tween import cat_pkg::*; ();

    localparam int WORD_TARGET = 1700;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 60;

    // one command word waiting to be sent
    typedef struct {
        logic                    cmd;
        logic signed [PIX_W-1:0] tx;
        logic signed [PIX_W-1:0] ty;
        logic        [FRM_W-1:0] frames;
        bit                      drain_first;
    } t_cmd_word;

    // one predicted scroll result
    typedef struct {
        logic signed [PIX_W-1:0] sx;
        logic signed [PIX_W-1:0] sy;
        logic                    moving;
        logic                    ended;
    } t_scroll;

    typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_PERIODIC} t_rx_mode;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    cat_in_if  in_if ();
    cat_out_if out_if ();

    constant_accel_scroll_tween DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #5 i_clk = ~i_clk;

    t_cmd_word pending_words[$];
    t_scroll   scroll_expect[$];
    t_cmd_word live_word;

    int mismatches = 0;
    int results_seen = 0;
    int retires_seen = 0;
    int starts_queued = 0;
    int ticks_queued = 0;
    int cycle_count = 0;

    // tween state mirrored from the block
    logic signed [PIX_W-1:0] cur_px = '0, cur_py = '0;
    logic signed [POS_W-1:0] pos_x = '0, pos_y = '0;
    logic signed [POS_W-1:0] goal_x = '0, goal_y = '0;
    logic signed [ACC_W-1:0] vel_x = '0, vel_y = '0;
    logic signed [ACC_W-1:0] acc_x = '0, acc_y = '0;
    logic        [FRM_W-1:0] frm_done = '0, frm_len = '0;
    bit                      running = 1'b0;

    // 2*(goal-pos)/len^2, truncating toward zero, zero for an empty duration
    function automatic logic signed [ACC_W-1:0] accel_toward(
        logic signed [POS_W-1:0] goal, logic signed [POS_W-1:0] pos, logic [FRM_W-1:0] len);
        longint num;
        longint den;
        if (len == '0) return '0;
        num = 2 * (longint'(goal) - longint'(pos));
        den = longint'(len) * longint'(len);
        return ACC_W'(num / den);
    endfunction

    // fixed-point position to whole pixels, truncated toward zero and saturated
    function automatic logic signed [PIX_W-1:0] pixel_of(logic signed [POS_W-1:0] p);
        int q;
        q = int'(p) / (1 << FRAC_BITS);
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return PIX_W'(q);
    endfunction

    // apply one command word to the mirrored state and form its result
    function automatic t_scroll advance_tween(t_cmd_word w);
        t_scroll r;
        r.ended = 1'b0;
        if (w.cmd == CMD_START) begin
            frm_len  = w.frames;
            frm_done = '0;
            pos_x    = POS_W'(longint'(cur_px) * (1 << FRAC_BITS));
            pos_y    = POS_W'(longint'(cur_py) * (1 << FRAC_BITS));
            goal_x   = POS_W'(longint'(w.tx) * (1 << FRAC_BITS));
            goal_y   = POS_W'(longint'(w.ty) * (1 << FRAC_BITS));
            vel_x    = '0;
            vel_y    = '0;
            acc_x    = accel_toward(goal_x, pos_x, frm_len);
            acc_y    = accel_toward(goal_y, pos_y, frm_len);
            running  = 1'b1;
        end else if (running) begin
            if (frm_done >= frm_len) begin
                running = 1'b0;
                r.ended = 1'b1;
            end else begin
                vel_x = vel_x + acc_x;
                vel_y = vel_y + acc_y;
                pos_x = POS_W'(longint'(pos_x) + longint'(vel_x));
                pos_y = POS_W'(longint'(pos_y) + longint'(vel_y));
                frm_done = frm_done + 1'b1;
                // last frame lands exactly on the goal
                if (frm_done >= frm_len) begin
                    pos_x = goal_x;
                    pos_y = goal_y;
                end
                cur_px = pixel_of(pos_x);
                cur_py = pixel_of(pos_y);
            end
        end
        r.sx = cur_px;
        r.sy = cur_py;
        r.moving = running;
        return r;
    endfunction

    // stimulus helpers
    task automatic queue_start(int tx, int ty, int frames, bit drain = 1'b0);
        t_cmd_word w;
        w.cmd = CMD_START;
        w.tx = PIX_W'(tx);
        w.ty = PIX_W'(ty);
        w.frames = FRM_W'(frames);
        w.drain_first = drain;
        pending_words.push_back(w);
        starts_queued++;
    endtask

    task automatic queue_ticks(int n);
        t_cmd_word w;
        w.tx = PIX_W'($urandom);
        w.ty = PIX_W'($urandom);
        w.frames = FRM_W'($urandom);
        w.cmd = CMD_TICK;
        w.drain_first = 1'b0;
        repeat (n) begin
            pending_words.push_back(w);
            ticks_queued++;
        end
    endtask

    // mostly full range, sometimes the rails or a short hop
    function automatic int pick_pixel();
        case ($urandom_range(0, 9))
            0: return 32767;
            1: return -32768;
            2: return $urandom_range(0, 64) - 32;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s expected %0d got %0d", $time, name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // driver: bursts of words with random gaps
    int gap_left = 0;
    int burst_left = 4;

    always @(posedge i_clk) begin
        logic take;
        take = 1'b0;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                scroll_expect.push_back(advance_tween(live_word));
            end
            if (!in_if.valid || in_if.ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (pending_words.size() != 0 &&
                             !(pending_words[0].drain_first && scroll_expect.size() != 0)) begin
                    take = 1'b1;
                end
                if (take) begin
                    live_word = pending_words.pop_front();
                    in_if.cmd    <= live_word.cmd;
                    in_if.dest_x <= live_word.tx;
                    in_if.dest_y <= live_word.ty;
                    in_if.frames <= live_word.frames;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else if ($urandom_range(0, 7) == 0) begin
                        // long stretch with no idling
                        gap_left = 0;
                        burst_left = $urandom_range(40, 150);
                    end else begin
                        gap_left = $urandom_range(1, 45);
                        burst_left = $urandom_range(1, 12);
                    end
                end
                in_if.valid <= take;
            end
        end
    end

    // receiver stall pattern and result checking
    t_rx_mode rx_mode = RX_OPEN;
    int rx_left = 0;

    always @(posedge i_clk) begin
        t_scroll e;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (scroll_expect.size() == 0) begin
                    $display("%0t: unexpected result word, expected none got x=%0d y=%0d",
                             $time, out_if.scroll_x, out_if.scroll_y);
                    mismatches++;
                end else begin
                    e = scroll_expect.pop_front();
                    check_field("scroll_x", int'(e.sx), int'(out_if.scroll_x));
                    check_field("scroll_y", int'(e.sy), int'(out_if.scroll_y));
                    check_field("moving", int'(e.moving), int'(out_if.moving));
                    check_field("ended", int'(e.ended), int'(out_if.ended));
                    results_seen++;
                    if (e.ended) retires_seen++;
                end
            end
            if (rx_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                rx_left = $urandom_range(50, 400);
            end else begin
                rx_left--;
            end
            case (rx_mode)
                RX_OPEN:     out_if.ready <= 1'b1;
                RX_COIN:     out_if.ready <= 1'($urandom_range(0, 1));
                RX_MOSTLY:   out_if.ready <= ($urandom_range(0, 9) != 0);
                RX_PERIODIC: out_if.ready <= ((cycle_count % 11) > 6);
                default:     out_if.ready <= 1'b1;
            endcase
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d words pending and %0d results outstanding",
                     $time, pending_words.size(), scroll_expect.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int frames;
        int n;
        in_if.valid = 1'b0;
        in_if.cmd = CMD_TICK;
        in_if.dest_x = '0;
        in_if.dest_y = '0;
        in_if.frames = '0;
        out_if.ready = 1'b0;

        // directed: idle tick, zero duration, rails, restart while moving, longest duration
        queue_ticks(1);
        queue_start(100, -100, 0);
        queue_ticks(2);
        queue_start(32767, -32768, 1);
        queue_ticks(2);
        queue_start(-32768, 32767, 3);
        queue_ticks(4);
        queue_start(0, 0, 5);
        queue_ticks(2);
        queue_start(-1, 1, 2);
        queue_ticks(3);
        queue_start(12345, -23456, 4095);
        queue_ticks(2);
        queue_start(7, -7, 2);
        queue_ticks(3);

        // random: mostly complete tweens, some cut short, some noise
        n = 0;
        while (starts_queued + ticks_queued < WORD_TARGET) begin
            case ($urandom_range(0, 19))
                0, 1: begin
                    // cut short by the next start, any duration
                    frames = $urandom_range(0, 4095);
                    queue_start(pick_pixel(), pick_pixel(), frames);
                    queue_ticks($urandom_range(0, 6));
                end
                2, 3: begin
                    queue_start(pick_pixel(), pick_pixel(), 0);
                    queue_ticks($urandom_range(0, 2));
                end
                4: queue_ticks($urandom_range(1, 3));
                default: begin
                    frames = ($urandom_range(0, 24) == 0) ? $urandom_range(25, 300)
                                                          : $urandom_range(1, 24);
                    queue_start(pick_pixel(), pick_pixel(), frames,
                                (n == 3) || ($urandom_range(0, 39) == 0));
                    queue_ticks(frames + 1 + (($urandom_range(0, 3) == 0) ?
                                              $urandom_range(1, 2) : 0));
                end
            endcase
            n++;
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // drain, then allow the block to settle
        while (pending_words.size() != 0 || in_if.valid || scroll_expect.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("run: %0d start words and %0d tick words sent, %0d results checked",
                 starts_queued, ticks_queued, results_seen);
        $display("run: %0d tweens retired by a tick, %0d mismatches", retires_seen, mismatches);
        if (mismatches == 0 && scroll_expect.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
